>>> sv/lbk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbk_pkg
// Types and constants shared by the lookback option path payoff block.
// ----------------------------------------------------------------------------
package lbk_pkg;

	localparam int PRICE_W = 32;
	localparam int WIN_W   = 16;
	localparam int DISC_W  = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int DISC_FRAC = 30;
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FLOATING_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IS_CALL         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIKE_PRICE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END      = 3'd5;

	localparam logic [DISC_W-1:0] DISC_RESET    = 32'h4000_0000;
	localparam logic [WIN_W-1:0]  WIN_END_RESET = 16'hFFFF;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               last_sample;
	} item_t;

	typedef struct packed {
		logic [PRICE_W-1:0] discounted_payoff;
		logic [PRICE_W-1:0] extreme_value;
		logic               window_empty;
		logic               path_end;
	} result_t;

	typedef struct packed {
		logic               floating_mode;
		logic               is_call;
		logic [PRICE_W-1:0] strike_price;
		logic [DISC_W-1:0]  discount_factor;
		logic [WIN_W-1:0]   window_start;
		logic [WIN_W-1:0]   window_end;
	} cfg_t;

	// finished path handed from front to back
	typedef struct packed {
		logic [PRICE_W-1:0] extreme;
		logic [PRICE_W-1:0] price;
		logic               seen;
	} path_rec_t;

endpackage
`default_nettype wire

>>> sv/lbk_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbk_queue
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module lbk_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr,
	input  wire logic [W-1:0]                 wr_data,
	input  wire logic                         rd,
	output logic      [W-1:0]                 rd_data,
	output logic                              full,
	output logic                              empty,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

>>> sv/lbk_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbk_front
// Sample indexing, window check and running extreme per path.
// ----------------------------------------------------------------------------
module lbk_front #(
	parameter int MAX_PATH_LEN = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lbk_pkg::cfg_t      cfg,
	input  wire logic               push,
	input  wire lbk_pkg::item_t     item,
	output logic                    full,
	input  wire logic               rec_full,
	output logic                    rec_push,
	output lbk_pkg::path_rec_t      rec
);

	localparam int IDX_W = $clog2(MAX_PATH_LEN);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PATH_LEN - 1);

	logic [IDX_W-1:0]             idx_q;
	logic [lbk_pkg::PRICE_W-1:0]  ext_q;
	logic                         seen_q;

	logic                         accept;
	logic                         take_max;
	logic [lbk_pkg::WIN_W-1:0]    idx_w;
	logic                         in_win;
	logic                         better;
	logic [lbk_pkg::PRICE_W-1:0]  ext_n;
	logic                         seen_n;

	assign full     = rec_full;
	assign accept   = push && !rec_full;
	assign take_max = cfg.is_call ^ cfg.floating_mode;
	assign idx_w    = lbk_pkg::WIN_W'(idx_q);
	assign in_win   = (idx_q != '0) && (idx_w > cfg.window_start)
		&& (idx_w <= cfg.window_end);
	assign better   = take_max ? (item.price > ext_q) : (item.price < ext_q);
	assign ext_n    = (in_win && (!seen_q || better)) ? item.price : ext_q;
	assign seen_n   = seen_q || in_win;

	assign rec_push    = accept && item.last_sample;
	assign rec.extreme = ext_n;
	assign rec.price   = item.price;
	assign rec.seen    = seen_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			ext_q  <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (item.last_sample) begin
				idx_q  <= '0;
				ext_q  <= '0;
				seen_q <= 1'b0;
			end else begin
				idx_q  <= (idx_q == IDX_MAX) ? idx_q : idx_q + 1'b1;
				ext_q  <= ext_n;
				seen_q <= seen_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/lbk_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbk_back
// Payoff, discount multiply with saturation, and result queue.
// ----------------------------------------------------------------------------
module lbk_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lbk_pkg::cfg_t        cfg,
	input  wire logic                 rec_empty,
	input  wire lbk_pkg::path_rec_t   rec,
	output logic                      rec_pop,
	input  wire logic                 pop,
	output logic                      empty,
	output lbk_pkg::result_t          result
);

	localparam int PW = lbk_pkg::PRICE_W;
	localparam int PRODW = PW + lbk_pkg::DISC_W;
	localparam int CW = $clog2(lbk_pkg::OUT_DEPTH + 1);

	logic            valid_s1;
	logic [PW-1:0]   payoff_s1;
	logic [PW-1:0]   ext_s1;
	logic            wempty_s1;

	logic            valid_s2;
	logic [PRODW-1:0] prod_s2;
	logic [PW-1:0]   ext_s2;
	logic            wempty_s2;

	logic [PW-1:0]   op_a;
	logic [PW-1:0]   op_b;
	logic [PW-1:0]   payoff;
	logic [PRODW-lbk_pkg::DISC_FRAC-1:0] scaled;
	lbk_pkg::result_t res_in;
	logic [CW-1:0]   out_count;
	logic [CW-1:0]   busy;
	logic            out_full;

	// difference operands by mode and option type
	always_comb begin
		if (cfg.floating_mode) begin
			op_a = cfg.is_call ? rec.price : rec.extreme;
			op_b = cfg.is_call ? rec.extreme : rec.price;
		end else begin
			op_a = cfg.is_call ? rec.extreme : cfg.strike_price;
			op_b = cfg.is_call ? cfg.strike_price : rec.extreme;
		end
		payoff = (rec.seen && (op_a > op_b)) ? op_a - op_b : '0;
	end

	assign busy    = out_count + CW'(valid_s1) + CW'(valid_s2);
	assign rec_pop = !rec_empty && (busy < CW'(lbk_pkg::OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= rec_pop;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		payoff_s1 <= payoff;
		ext_s1    <= rec.seen ? rec.extreme : '0;
		wempty_s1 <= !rec.seen;
		prod_s2   <= PRODW'(payoff_s1) * PRODW'(cfg.discount_factor);
		ext_s2    <= ext_s1;
		wempty_s2 <= wempty_s1;
	end

	assign scaled = prod_s2[PRODW-1:lbk_pkg::DISC_FRAC];

	always_comb begin
		res_in.discounted_payoff = (|scaled[PRODW-lbk_pkg::DISC_FRAC-1:PW]) ? '1
			: scaled[PW-1:0];
		res_in.extreme_value = ext_s2;
		res_in.window_empty  = wempty_s2;
		res_in.path_end      = 1'b1;
	end

	lbk_queue #(
		.W     ($bits(lbk_pkg::result_t)),
		.DEPTH (lbk_pkg::OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (valid_s2),
		.wr_data (res_in),
		.rd      (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty),
		.count   (out_count)
	);

	logic unused_full;
	assign unused_full = out_full;

endmodule
`default_nettype wire

>>> sv/lookback_option_path_payoff.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lookback_option_path_payoff
// Lookback option payoff over a streamed price path.
// ----------------------------------------------------------------------------
// result path: last sample -> mid queue -> payoff and product registers -> result queue
// throughput: one sample per cycle while the mid queue has room (full stalls samples),
//   one path result per cycle while the result queue and its pipeline have room
// reset: asynchronous, clears path state and both queues, registers to defaults
// ----------------------------------------------------------------------------
module lookback_option_path_payoff #(
	parameter int MAX_PATH_LEN = 65536
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	input  wire lbk_pkg::item_t                    item,
	output logic                                   full,
	output logic                                   empty,
	input  wire logic                              pop,
	output lbk_pkg::result_t                       result,
	input  wire logic                              cfg_write,
	input  wire logic [lbk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lbk_pkg::CFG_W-1:0]         cfg_data
);

	lbk_pkg::cfg_t      cfg_q;
	lbk_pkg::path_rec_t rec_wr;
	lbk_pkg::path_rec_t rec_rd;
	logic               rec_push;
	logic               rec_pop;
	logic               rec_full;
	logic               rec_empty;
	logic [$clog2(lbk_pkg::MID_DEPTH+1)-1:0] rec_count;
	logic               unused_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floating_mode   <= 1'b0;
			cfg_q.is_call         <= 1'b1;
			cfg_q.strike_price    <= '0;
			cfg_q.discount_factor <= lbk_pkg::DISC_RESET;
			cfg_q.window_start    <= '0;
			cfg_q.window_end      <= lbk_pkg::WIN_END_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				lbk_pkg::REG_FLOATING_MODE: begin
					cfg_q.floating_mode <= cfg_data[0];
				end
				lbk_pkg::REG_IS_CALL: begin
					cfg_q.is_call <= cfg_data[0];
				end
				lbk_pkg::REG_STRIKE_PRICE: begin
					cfg_q.strike_price <= cfg_data[lbk_pkg::PRICE_W-1:0];
				end
				lbk_pkg::REG_DISCOUNT_FACTOR: begin
					cfg_q.discount_factor <= cfg_data[lbk_pkg::DISC_W-1:0];
				end
				lbk_pkg::REG_WINDOW_START: begin
					cfg_q.window_start <= cfg_data[lbk_pkg::WIN_W-1:0];
				end
				lbk_pkg::REG_WINDOW_END: begin
					cfg_q.window_end <= cfg_data[lbk_pkg::WIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	lbk_front #(
		.MAX_PATH_LEN (MAX_PATH_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.item     (item),
		.full     (full),
		.rec_full (rec_full),
		.rec_push (rec_push),
		.rec      (rec_wr)
	);

	lbk_queue #(
		.W     ($bits(lbk_pkg::path_rec_t)),
		.DEPTH (lbk_pkg::MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (rec_push),
		.wr_data (rec_wr),
		.rd      (rec_pop),
		.rd_data (rec_rd),
		.full    (rec_full),
		.empty   (rec_empty),
		.count   (rec_count)
	);

	assign unused_count = |rec_count;

	lbk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec_empty (rec_empty),
		.rec       (rec_rd),
		.rec_pop   (rec_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
`default_nettype wire
